>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the design
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SIDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SIDA_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/sida_pkg.sv
// ---------------------------------------------------------------------------
// sida_pkg
// types and constants for the signed integer to decimal text converter
// ---------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  typedef logic [3:0]       digit_t;
  typedef logic [5:0]       char_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam char_t CHAR_ZERO  = 6'd48;
  localparam char_t CHAR_MINUS = 6'd45;

  // ceil(2^35 / 10): floor(x * RECIP_10 / 2^35) == x / 10 for every 32-bit x
  localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;
  localparam int unsigned DIV_SHIFT = 35;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIG  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

>>> design/sida_div10.sv
// ---------------------------------------------------------------------------
// sida_div10
// divide by ten through a reciprocal multiply, with the product registered
// ---------------------------------------------------------------------------
module sida_div10 (
  input  logic                clk,
  input  logic [31:0]         mag_i,
  output logic [31:0]         quot_o,
  output sida_pkg::digit_t    rem_o
);

  logic [63:0] prod_r;
  logic [3:0]  mag_lo_r;
  logic [3:0]  q_lo;
  logic [3:0]  q10_lo;

  always_ff @(posedge clk) begin
    prod_r   <= 64'(mag_i) * 64'(sida_pkg::RECIP_10);
    mag_lo_r <= mag_i[3:0];
  end

  assign quot_o = 32'(prod_r[63:sida_pkg::DIV_SHIFT]);
  assign q_lo   = quot_o[3:0];

  // remainder is below ten, so the low four bits of mag - 10*q are enough
  assign q10_lo = 4'({q_lo, 3'b000} + {2'b00, q_lo, 1'b0});
  assign rem_o  = mag_lo_r - q10_lo;

endmodule

>>> design/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// converts a 32-bit signed integer to its decimal ascii text, msd first
// ---------------------------------------------------------------------------
// channel | dir | payload                          | end marker
// in_     | in  | tdata[31:0] value                | -
// out_    | out | tdata[5:0] text_char, [7:6] zero | tlast on final char
//
// steps: accept, then per digit the shared divide-by-ten unit (multiply, then
//   remainder), then one char per cycle out while out_tready is high
// reset: rst_n synchronous, clears the sequencer and the output valid
// stalls: out_tready low holds the current char; in_tready only when idle
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] text_char, [7:6] zero
  output logic        out_tlast
);

  sida_pkg::state_t state_r, state_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  sida_pkg::cnt_t   ndig_r, ndig_nxt;
  sida_pkg::digit_t digit_r   [sida_pkg::MAX_DIGITS];
  sida_pkg::digit_t digit_nxt [sida_pkg::MAX_DIGITS];
  logic             out_valid_r, out_valid_nxt;
  sida_pkg::char_t  out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [31:0]      div_quot;
  sida_pkg::digit_t div_rem;
  logic             out_ld;

  sida_div10 u_div10 (
    .clk    (clk),
    .mag_i  (mag_r),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  assign in_tready  = (state_r == sida_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_char_r};
  assign out_tlast  = out_last_r;
  assign out_ld     = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    sign_pend_nxt = sign_pend_r;
    ndig_nxt      = ndig_r;
    digit_nxt     = digit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      sida_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          sign_pend_nxt = in_tdata[31];
          mag_nxt       = in_tdata[31] ? (~in_tdata + 32'd1) : in_tdata;
          ndig_nxt      = '0;
          state_nxt     = sida_pkg::ST_MUL;
        end
      end
      sida_pkg::ST_MUL: begin
        state_nxt = sida_pkg::ST_DIG;
      end
      sida_pkg::ST_DIG: begin
        // push digit onto the stack, lsd first so msd ends on top
        digit_nxt[0] = div_rem;
        for (int i = 1; i < sida_pkg::MAX_DIGITS; i++) begin
          digit_nxt[i] = digit_r[i-1];
        end
        ndig_nxt = ndig_r + sida_pkg::cnt_t'(1);
        mag_nxt  = div_quot;
        if (div_quot == 32'd0) begin
          state_nxt = sida_pkg::ST_EMIT;
        end else begin
          state_nxt = sida_pkg::ST_MUL;
        end
      end
      sida_pkg::ST_EMIT: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = sida_pkg::CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = sida_pkg::CHAR_ZERO + {2'b00, digit_r[0]};
            out_last_nxt = (ndig_r == sida_pkg::cnt_t'(1));
            for (int i = 0; i < sida_pkg::MAX_DIGITS - 1; i++) begin
              digit_nxt[i] = digit_r[i+1];
            end
            ndig_nxt = ndig_r - sida_pkg::cnt_t'(1);
            if (ndig_r == sida_pkg::cnt_t'(1)) begin
              state_nxt = sida_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = sida_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sida_pkg::ST_IDLE;
      ndig_r      <= '0;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ndig_r      <= ndig_nxt;
      sign_pend_r <= sign_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digit_r    <= digit_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  `SIDA_ASSERT(a_rem_decimal, clk, rst_n,
    (state_r == sida_pkg::ST_DIG) |-> (div_rem < 4'd10), "divide unit gave a remainder above nine")
  `SIDA_ASSERT(a_idle_empty, clk, rst_n,
    (state_r == sida_pkg::ST_IDLE) |-> (ndig_r == '0 && !sign_pend_r), "idle with digits still stacked")
  `SIDA_NEVER(a_stack_bound, clk, rst_n,
    ndig_r > sida_pkg::cnt_t'(sida_pkg::MAX_DIGITS), "digit stack overflow")
  `SIDA_NEVER(a_pop_empty, clk, rst_n,
    state_r == sida_pkg::ST_EMIT && !sign_pend_r && ndig_r == '0, "emitting from an empty digit stack")

endmodule

>>> tb/signed_int_to_decimal_ascii_test.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// streams signed integers into the converter and checks every ascii char
// against locally predicted decimal text, with random idling on both sides
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int unsigned RADIX      = 10;
  localparam int          STALL_MAX  = 8;
  localparam int          HANG_LIMIT = 2000;
  localparam int          TAIL_WAIT  = 40;
  localparam int          N_RANDOM   = 180;
  localparam int          N_CALM     = 30;

  typedef struct packed {
    sida_pkg::char_t text_char;
    logic            last;
  } text_item_t;

  // holds the expected characters, not yet checked, of every number accepted so far
  class decimal_text_board;
    text_item_t pending_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void add_number(logic [31:0] raw);
      logic [31:0]      mag;
      sida_pkg::digit_t digs[$];
      int               k;
      mag = raw[31] ? (~raw + 32'd1) : raw;
      // zero still gives one digit
      do begin
        digs.push_back(sida_pkg::digit_t'(mag % RADIX));
        mag = mag / RADIX;
      end while (mag != 0);
      if (raw[31]) pending_chars.push_back('{sida_pkg::CHAR_MINUS, 1'b0});
      for (k = digs.size() - 1; k >= 0; k--) begin
        pending_chars.push_back('{sida_pkg::char_t'(sida_pkg::CHAR_ZERO + digs[k]), k == 0});
      end
    endfunction

    function void check_char(logic [7:0] tdata, logic tlast);
      text_item_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected item: text_char actual %0d, last actual %0d", tdata[5:0], tlast);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (tdata[5:0] !== want.text_char) begin
        $error("text_char: expected %0d, actual %0d", want.text_char, tdata[5:0]);
        errors++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, tlast);
        errors++;
      end
      if (tdata[7:6] !== 2'b00) begin
        $error("pad: expected 0, actual %0d", tdata[7:6]);
        errors++;
      end
    endfunction

    function int pending_count();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [5:0] text_char, [7:6] zero
  logic        out_tlast;

  decimal_text_board board;
  bit                idle_on;

  signed_int_to_decimal_ascii uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    idle_on    = 1'b1;
    board      = new();
  end

  always #5 clk = ~clk;

  // result side: check accepted chars, then pick next ready
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_char(out_tdata, out_tlast);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, STALL_MAX) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // hang detection: cycles in which neither channel moves an item
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= HANG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_value(input logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    board.add_number(v);
  endtask

  task automatic drain_text();
    in_tvalid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    longint unsigned pow10;
    longint unsigned mag;
    int              k;
    logic [31:0]     v;
    case ($urandom_range(0, 2))
      0: v = $urandom;
      1: begin
        // random digit count, random sign
        k = $urandom_range(1, 10);
        pow10 = 1;
        repeat (k) pow10 = pow10 * RADIX;
        mag = longint'($urandom) % pow10;
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        v = mag[31:0];
        if ($urandom_range(0, 1)) v = ~v + 32'd1;
      end
      default: begin
        // around a power of ten
        k = $urandom_range(0, 9);
        pow10 = 1;
        repeat (k) pow10 = pow10 * RADIX;
        mag = pow10 + $urandom_range(0, 2) - 1;
        v = mag[31:0];
        if ($urandom_range(0, 1)) v = ~v + 32'd1;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] directed[$];
    int          i;
    directed = {32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                32'd1000000000, 32'd999999999, 32'hC465_3601, 32'd123456789,
                32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FF9C};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[j]) send_value(directed[j]);
    drain_text();

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) idle_on = 1'b0;
      send_value(pick_value());
      if (idle_on && $urandom_range(0, 19) == 0) drain_text();
    end
    in_tvalid <= 1'b0;

    while (board.pending_count() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (board.pending_count() != 0) begin
      $error("text chars never arrived: %0d", board.pending_count());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sida_pkg.sv
design/sida_div10.sv
design/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
